// ----- rtl/bevt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the button event generator.
// No dependencies; compiled first.
package bevt_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned HOLD_W     = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		EV_TOUCH_PRESS   = 3'd0,
		EV_TOUCH_RELEASE = 3'd1,
		EV_LONG_PRESS    = 3'd2,
		EV_TALK_PRESS    = 3'd3,
		EV_TALK_RELEASE  = 3'd4,
		EV_TICK          = 3'd5
	} bevt_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOUCH_ACTIVE_HIGH = 2'd0,
		CFG_PTT_ACTIVE_LOW    = 2'd1,
		CFG_LONG_PRESS_MS     = 2'd2,
		CFG_TICK_PERIOD_MS    = 2'd3
	} bevt_cfg_t;

	localparam logic [HOLD_W-1:0] LONG_PRESS_RST  = 16'd2000;
	localparam logic [HOLD_W-1:0] TICK_PERIOD_RST = 16'd1000;

endpackage

// ----- rtl/bevt_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pin samples and button events.
// Depends on bevt_pkg.
interface bevt_sample_if;
	import bevt_pkg::*;
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] now_ms;
	logic              touch_level;
	logic              talk_level;

	modport source (output valid, now_ms, touch_level, talk_level, input ready);
	modport sink   (input valid, now_ms, touch_level, talk_level, output ready);
endinterface

interface bevt_event_if;
	import bevt_pkg::*;
	logic              valid;
	logic              ready;
	bevt_kind_t        event_kind;
	logic [TIME_W-1:0] held_ms;
	logic [TIME_W-1:0] stamp_ms;
	logic              last_of_run;

	modport source (output valid, event_kind, held_ms, stamp_ms, last_of_run, input ready);
	modport sink   (input valid, event_kind, held_ms, stamp_ms, last_of_run, output ready);
endinterface

// ----- rtl/button_event_generator.sv -----
`timescale 1ns / 1ps
// Button event generator: touch press/release/long press, talk press/release, tick.
// Depends on bevt_pkg and bevt_if.
//
//  channel | dir | request carries
//  --------+-----+------------------------------------------------
//  smp     | in  | now_ms, touch_level, talk_level
//  evt     | out | event_kind, held_ms, stamp_ms, last_of_run
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A sample is registered, then evaluated combinationally into an event buffer
// of up to three events, which drains one event per cycle while evt is ready.
// A sample with events occupies the buffer until its last event is taken; the
// input stage holds the next sample meanwhile.
// Samples are taken while the buffer drains its last event; a stalled evt
// holds the buffer and backs up into smp. Reset clears state and restores config defaults.
module button_event_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bevt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bevt_pkg::CFG_DATA_W-1:0]   cfg_data,
	bevt_sample_if.sink                       smp,
	bevt_event_if.source                      evt
);
	import bevt_pkg::*;

	localparam int unsigned PAD_W = TIME_W - HOLD_W;

	// configuration
	logic              touch_hi_q;
	logic              ptt_lo_q;
	logic [HOLD_W-1:0] long_press_q;
	logic [HOLD_W-1:0] tick_period_q;

	// block state
	logic              touch_was_q;
	logic [TIME_W-1:0] touch_start_q;
	logic              lp_sent_q;
	logic              talk_was_q;
	logic [TIME_W-1:0] last_tick_q;

	// input stage
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic              touch_s1;
	logic              talk_s1;

	// event buffer: bit 0 touch slot, bit 1 talk slot, bit 2 tick
	logic [2:0]        pend_q;
	logic [TIME_W-1:0] stamp_q;
	bevt_kind_t        touch_kind_q;
	logic [TIME_W-1:0] held_q;
	bevt_kind_t        talk_kind_q;

	logic              smp_fire;
	logic              out_fire;
	logic              out_last;
	logic              buf_free;
	logic              s1_adv;
	logic [2:0]        pend_drop;

	logic              touch_act;
	logic              talk_act;
	logic [TIME_W-1:0] touch_diff;
	logic [TIME_W-1:0] tick_diff;
	logic [HOLD_W-1:0] hold;
	logic              t_press;
	logic              t_rel;
	logic              t_long;
	logic              k_press;
	logic              k_rel;
	logic              tick_hit;
	logic [2:0]        new_mask;
	bevt_kind_t        touch_kind_d;
	bevt_kind_t        talk_kind_d;
	logic [TIME_W-1:0] held_d;

	// handshakes
	assign pend_drop = pend_q & (pend_q - 3'd1);
	assign out_last  = (pend_q != 3'd0) && (pend_drop == 3'd0);
	assign out_fire  = evt.valid && evt.ready;
	assign buf_free  = (pend_q == 3'd0) || (out_fire && out_last);
	assign s1_adv    = valid_s1 && buf_free;
	assign smp.ready = !valid_s1 || buf_free;
	assign smp_fire  = smp.valid && smp.ready;

	// event evaluation on the registered sample
	always_comb begin
		touch_act  = touch_s1 ~^ touch_hi_q;
		talk_act   = talk_s1 ^ ptt_lo_q;
		touch_diff = now_s1 - touch_start_q;
		tick_diff  = now_s1 - last_tick_q;
		hold       = (long_press_q == '0) ? HOLD_W'(1) : long_press_q;
		t_press    = touch_act && !touch_was_q;
		t_rel      = !touch_act && touch_was_q;
		// a fresh press has zero hold time, so only an ongoing touch can go long
		t_long     = touch_act && touch_was_q && !lp_sent_q
			&& (touch_diff >= {{PAD_W{1'b0}}, hold});
		k_press    = talk_act && !talk_was_q;
		k_rel      = !talk_act && talk_was_q;
		tick_hit   = tick_diff >= {{PAD_W{1'b0}}, tick_period_q};
		new_mask   = {tick_hit, k_press || k_rel, t_press || t_rel || t_long};
		if (t_press) begin
			touch_kind_d = EV_TOUCH_PRESS;
		end else if (t_rel) begin
			touch_kind_d = EV_TOUCH_RELEASE;
		end else begin
			touch_kind_d = EV_LONG_PRESS;
		end
		held_d      = t_press ? '0 : touch_diff;
		talk_kind_d = k_press ? EV_TALK_PRESS : EV_TALK_RELEASE;
	end

	// output selection: lowest pending slot goes first
	always_comb begin
		evt.valid       = pend_q != 3'd0;
		evt.stamp_ms    = stamp_q;
		evt.last_of_run = out_last;
		if (pend_q[0]) begin
			evt.event_kind = touch_kind_q;
			evt.held_ms    = held_q;
		end else if (pend_q[1]) begin
			evt.event_kind = talk_kind_q;
			evt.held_ms    = '0;
		end else begin
			evt.event_kind = EV_TICK;
			evt.held_ms    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_hi_q    <= 1'b1;
			ptt_lo_q      <= 1'b1;
			long_press_q  <= LONG_PRESS_RST;
			tick_period_q <= TICK_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOUCH_ACTIVE_HIGH: touch_hi_q    <= cfg_data[0];
				CFG_PTT_ACTIVE_LOW:    ptt_lo_q      <= cfg_data[0];
				CFG_LONG_PRESS_MS:     long_press_q  <= cfg_data[HOLD_W-1:0];
				CFG_TICK_PERIOD_MS:    tick_period_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_was_q   <= 1'b0;
			touch_start_q <= '0;
			lp_sent_q     <= 1'b0;
			talk_was_q    <= 1'b0;
			last_tick_q   <= '0;
		end else if (s1_adv) begin
			touch_was_q <= touch_act;
			talk_was_q  <= talk_act;
			if (t_press) begin
				touch_start_q <= now_s1;
				lp_sent_q     <= 1'b0;
			end else if (t_long) begin
				lp_sent_q <= 1'b1;
			end
			if (tick_hit) begin
				last_tick_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_q   <= 3'd0;
		end else begin
			if (smp_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				pend_q <= new_mask;
			end else if (out_fire) begin
				pend_q <= pend_drop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp_fire) begin
			now_s1   <= smp.now_ms;
			touch_s1 <= smp.touch_level;
			talk_s1  <= smp.talk_level;
		end
		if (s1_adv) begin
			stamp_q      <= now_s1;
			touch_kind_q <= touch_kind_d;
			held_q       <= held_d;
			talk_kind_q  <= talk_kind_d;
		end
	end

endmodule

// ----- rtl/bevt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for button_event_generator, attached by bind.
// Depends on bevt_pkg.
module bevt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [2:0]                    event_kind,
	input logic [bevt_pkg::TIME_W-1:0]   held_ms,
	input logic [bevt_pkg::TIME_W-1:0]   stamp_ms,
	input logic                          last_of_run
);
	import bevt_pkg::*;

	// stalled event holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind)
			&& $stable(stamp_ms) && $stable(held_ms) && $stable(last_of_run))
		else $error("event changed while stalled");

	// events of one run follow directly and share the sample stamp
	a_run_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && $stable(stamp_ms))
		else $error("run broken or stamp changed inside run");

	// the tick is always the final event of a run
	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_TICK |-> last_of_run)
		else $error("tick not last of run");

	// only touch release and long press carry a hold time
	a_held_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_TOUCH_RELEASE && event_kind != EV_LONG_PRESS
			|-> held_ms == '0)
		else $error("held_ms nonzero on event without hold time");

endmodule

bind button_event_generator bevt_checker u_bevt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (evt.valid),
	.out_ready   (evt.ready),
	.event_kind  (evt.event_kind),
	.held_ms     (evt.held_ms),
	.stamp_ms    (evt.stamp_ms),
	.last_of_run (evt.last_of_run)
);
